@@ rtl/tpwv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpwv_pkg : shared types and constants
// field widths, command and decision codes, and the queued command format
// ----------------------------------------------------------------------------
package tpwv_pkg;

    localparam int FEAT_W      = 32;
    localparam int INDEX_W     = 6;
    localparam int WEIGHT_IN_W = 16;
    localparam int SCORE_W     = 22;
    localparam int MAX_SLOTS   = 2 ** INDEX_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef enum logic {
        OP_WRITE    = 1'b0,
        OP_CLASSIFY = 1'b1
    } tpwv_op_t;

    typedef enum logic [1:0] {
        DEC_ZERO      = 2'd0,
        DEC_ONE       = 2'd1,
        DEC_UNDECIDED = 2'd2
    } tpwv_decision_t;

    // decoded command; care_values carries the object bits for a classify
    typedef struct packed {
        tpwv_op_t               op;
        logic                   in_range;
        logic [INDEX_W-1:0]     entry_index;
        logic                   entry_valid;
        logic                   entry_class;
        logic [FEAT_W-1:0]      care_mask;
        logic [FEAT_W-1:0]      care_values;
        logic [WEIGHT_IN_W-1:0] entry_weight;
    } tpwv_cmd_t;

endpackage
`default_nettype wire

@@ rtl/tpwv_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpwv_if : item and result channels
// valid/ready channels carrying the input item and the result item
// ----------------------------------------------------------------------------
interface tpwv_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [5:0]  entry_index;
    logic        entry_valid;
    logic        entry_class;
    logic [31:0] care_mask;
    logic [31:0] care_values;
    logic [15:0] entry_weight;
    logic [31:0] object_bits;

    modport source (
        output valid, cmd, entry_index, entry_valid, entry_class,
               care_mask, care_values, entry_weight, object_bits,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_valid, entry_class,
               care_mask, care_values, entry_weight, object_bits,
        output ready
    );
endinterface

interface tpwv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  decision;
    logic [21:0] score_zero;
    logic [21:0] score_one;

    modport source (
        output valid, decision, score_zero, score_one,
        input  ready
    );
    modport sink (
        input  valid, decision, score_zero, score_one,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/tpwv_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpwv_front : item intake and decode
// takes items while the queue has room, sorts writes from classifies
// ----------------------------------------------------------------------------
module tpwv_front #(
    parameter int NUM_FEATURES = 32,
    parameter int NUM_PATTERNS = 64
) (
    tpwv_in_if.sink              item,
    input  logic                 q_full,
    output logic                 push,
    output tpwv_pkg::tpwv_cmd_t  cmd
);

    localparam int DEPTH = (NUM_PATTERNS < tpwv_pkg::MAX_SLOTS) ?
                           NUM_PATTERNS : tpwv_pkg::MAX_SLOTS;
    localparam logic [tpwv_pkg::FEAT_W-1:0] FEAT_MASK =
        (NUM_FEATURES >= tpwv_pkg::FEAT_W) ? {tpwv_pkg::FEAT_W{1'b1}} :
        tpwv_pkg::FEAT_W'((64'd1 << NUM_FEATURES) - 64'd1);

    assign item.ready = !q_full;
    assign push       = item.valid && !q_full;

    always_comb
    begin
        cmd              = '0;
        cmd.op           = tpwv_pkg::tpwv_op_t'(item.cmd);
        cmd.entry_index  = item.entry_index;
        cmd.in_range     = ({1'b0, item.entry_index} < (tpwv_pkg::INDEX_W + 1)'(DEPTH));
        cmd.entry_valid  = item.entry_valid;
        cmd.entry_class  = item.entry_class;
        cmd.entry_weight = item.entry_weight;
        unique case (cmd.op)
            tpwv_pkg::OP_WRITE:
            begin
                // features past the configured count never take part
                cmd.care_mask   = item.care_mask & FEAT_MASK;
                cmd.care_values = item.care_values;
            end
            tpwv_pkg::OP_CLASSIFY:
            begin
                cmd.care_mask   = '0;
                cmd.care_values = item.object_bits;
            end
            default:
            begin
                cmd.care_mask   = '0;
                cmd.care_values = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/tpwv_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpwv_queue : command queue
// short fifo between intake and execution
// ----------------------------------------------------------------------------
module tpwv_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tpwv_pkg::tpwv_cmd_t  push_cmd,
    output logic                 full,
    input  logic                 pop,
    output tpwv_pkg::tpwv_cmd_t  head,
    output logic                 empty
);

    localparam int PTR_W = $clog2(tpwv_pkg::QUEUE_DEPTH);

    tpwv_pkg::tpwv_cmd_t slot_reg [tpwv_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W:0]      count_reg;

    assign full  = (count_reg == (PTR_W + 1)'(tpwv_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            priority if (push && !pop)
            begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/tpwv_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpwv_back : pattern table and vote engine
// stores entries, walks the table one entry a cycle for a classify
// ----------------------------------------------------------------------------
module tpwv_back #(
    parameter int NUM_PATTERNS = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  tpwv_pkg::tpwv_cmd_t  head,
    output logic                 pop,
    tpwv_out_if.source           result
);

    localparam int DEPTH   = (NUM_PATTERNS < tpwv_pkg::MAX_SLOTS) ?
                             NUM_PATTERNS : tpwv_pkg::MAX_SLOTS;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WB      = (WEIGHT_BITS < tpwv_pkg::WEIGHT_IN_W) ?
                             WEIGHT_BITS : tpwv_pkg::WEIGHT_IN_W;
    localparam int FW      = tpwv_pkg::FEAT_W;
    localparam int SW      = tpwv_pkg::SCORE_W;
    localparam int ENTRY_W = 1 + 2 * FW + WB;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LAST,
        S_FINISH
    } state_t;

    state_t                   state_reg;
    logic [ENTRY_W-1:0]       mem [DEPTH];
    logic [DEPTH-1:0]         slot_valid_reg;
    logic [ENTRY_W-1:0]       rd_data_reg;
    logic                     rd_live_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         addr_reg;
    logic [FW-1:0]            obj_reg;
    logic [SW-1:0]            score_zero_reg;
    logic [SW-1:0]            score_one_reg;
    logic [SW-1:0]            score_zero_next;
    logic [SW-1:0]            score_one_next;
    tpwv_pkg::tpwv_decision_t decision_reg;
    logic                     out_valid_reg;
    logic                     out_free;
    logic                     out_set;
    logic                     mem_we;
    logic [IDX_W-1:0]         wr_addr;
    logic                     rd_class;
    logic [FW-1:0]            rd_mask;
    logic [FW-1:0]            rd_values;
    logic [WB-1:0]            rd_weight;
    logic                     hit;
    logic [SW:0]              sum;
    logic [SW-1:0]            sat_sum;

    assign out_free = !out_valid_reg || result.ready;
    assign pop      = (state_reg == S_IDLE) && !q_empty && out_free;
    assign mem_we   = pop && (head.op == tpwv_pkg::OP_WRITE) && head.in_range;
    assign wr_addr  = head.entry_index[IDX_W-1:0];

    // a write acknowledge or a finished classify loads the result register
    assign out_set  = (pop && (head.op == tpwv_pkg::OP_WRITE)) || (state_reg == S_FINISH);

    assign {rd_class, rd_mask, rd_values, rd_weight} = rd_data_reg;

    // match and saturating add for the entry read last cycle
    always_comb
    begin
        hit = rd_live_reg && rd_vld_reg && (((rd_values ^ obj_reg) & rd_mask) == '0);
        sum = rd_class ? {1'b0, score_one_reg} : {1'b0, score_zero_reg};
        sum = sum + (SW + 1)'(rd_weight);
        sat_sum = sum[SW] ? tpwv_pkg::SCORE_MAX : sum[SW-1:0];
        score_zero_next = score_zero_reg;
        score_one_next  = score_one_reg;
        if (hit && rd_class)
        begin
            score_one_next = sat_sum;
        end
        else if (hit)
        begin
            score_zero_next = sat_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {head.entry_class, head.care_mask, head.care_values,
                             head.entry_weight[WB-1:0]};
        end
        if (state_reg == S_WALK)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            rd_live_reg    <= 1'b0;
            rd_vld_reg     <= 1'b0;
            addr_reg       <= '0;
            obj_reg        <= '0;
            score_zero_reg <= '0;
            score_one_reg  <= '0;
            decision_reg   <= tpwv_pkg::DEC_UNDECIDED;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        score_zero_reg <= '0;
                        score_one_reg  <= '0;
                        addr_reg       <= '0;
                        rd_live_reg    <= 1'b0;
                        if (head.op == tpwv_pkg::OP_WRITE)
                        begin
                            if (head.in_range)
                            begin
                                slot_valid_reg[wr_addr] <= head.entry_valid;
                            end
                            decision_reg <= tpwv_pkg::DEC_UNDECIDED;
                        end
                        else
                        begin
                            obj_reg   <= head.care_values;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    rd_vld_reg     <= slot_valid_reg[addr_reg];
                    rd_live_reg    <= 1'b1;
                    score_zero_reg <= score_zero_next;
                    score_one_reg  <= score_one_next;
                    if (addr_reg == IDX_W'(DEPTH - 1))
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + IDX_W'(1);
                    end
                end
                S_LAST:
                begin
                    score_zero_reg <= score_zero_next;
                    score_one_reg  <= score_one_next;
                    rd_live_reg    <= 1'b0;
                    state_reg      <= S_FINISH;
                end
                S_FINISH:
                begin
                    priority if (score_zero_reg > score_one_reg)
                    begin
                        decision_reg <= tpwv_pkg::DEC_ZERO;
                    end
                    else if (score_zero_reg < score_one_reg)
                    begin
                        decision_reg <= tpwv_pkg::DEC_ONE;
                    end
                    else
                    begin
                        decision_reg <= tpwv_pkg::DEC_UNDECIDED;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.decision   = decision_reg;
    assign result.score_zero = score_zero_reg;
    assign result.score_one  = score_one_reg;

endmodule
`default_nettype wire

@@ rtl/ternary_pattern_weighted_vote.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ternary_pattern_weighted_vote : ternary pattern table with weighted vote
// usage:
//   item channel (valid/ready): cmd 0 writes one table entry, cmd 1
//   classifies object_bits against every valid entry
//   result channel (valid/ready): one result transaction per item; a write
//   returns decision 2 with both scores zero, a classify returns both class
//   scores and decision 0, 1, or 2 on a tie
//   a write result is registered as the write leaves the queue, a classify
//   result after the table walk (capped at 64 table slots) and the score compare;
//   one write per cycle while results are taken; a classify blocks the next
//   command during its walk, which reads one entry a cycle from a single port
//   reset clears all valid bits, the queue and the result register; the
//   block takes items in the first cycle after reset
//   a stalled result holds its payload; the 2-deep command queue keeps
//   taking items until it fills, then ready drops
// ----------------------------------------------------------------------------
module ternary_pattern_weighted_vote #(
    parameter int NUM_FEATURES = 32,
    parameter int NUM_PATTERNS = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    tpwv_in_if.sink     item,
    tpwv_out_if.source  result
);

    // decoded command from intake to the queue
    tpwv_pkg::tpwv_cmd_t push_cmd;
    logic                push;
    logic                q_full;

    // queue head to the vote engine
    tpwv_pkg::tpwv_cmd_t head;
    logic                q_empty;
    logic                pop;

    // intake: decode and range check, feature masking of the care mask
    tpwv_front #(
        .NUM_FEATURES (NUM_FEATURES),
        .NUM_PATTERNS (NUM_PATTERNS)
    ) u_front (
        .item   (item),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    // decouples intake from the table walk
    tpwv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    // pattern table, walk, scoring and the result register
    tpwv_back #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire

@@ rtl/tpwv_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpwv_checker : result channel checks
// decision agrees with the scores, stalled results hold
// ----------------------------------------------------------------------------
module tpwv_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        res_valid,
    input wire        res_ready,
    input wire [1:0]  decision,
    input wire [21:0] score_zero,
    input wire [21:0] score_one
);

    a_dec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && decision == tpwv_pkg::DEC_ZERO |-> score_zero > score_one)
        else $error("class zero decision without larger class zero score");

    a_dec_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && decision == tpwv_pkg::DEC_ONE |-> score_one > score_zero)
        else $error("class one decision without larger class one score");

    a_dec_tie: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && decision == tpwv_pkg::DEC_UNDECIDED |-> score_one == score_zero)
        else $error("undecided result with unequal scores");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(decision)
            && $stable(score_zero) && $stable(score_one))
        else $error("stalled result changed");

endmodule

bind ternary_pattern_weighted_vote tpwv_checker u_tpwv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .decision   (result.decision),
    .score_zero (result.score_zero),
    .score_one  (result.score_one)
);
`default_nettype wire

@@ tb/ternary_pattern_weighted_vote_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ternary_pattern_weighted_vote_tb : self-checking bench for the pattern vote
// writes ternary entries and classifies objects over the valid/ready channels;
// a local copy of the pattern table predicts every result transaction, which
// is checked in order while sender and receiver idle in several phases
// ----------------------------------------------------------------------------
module ternary_pattern_weighted_vote_tb;

    localparam int NUM_FEATURES = 32;
    localparam int NUM_PATTERNS = 64;
    localparam int WEIGHT_BITS  = 16;
    localparam int RANDOM_ITEMS = 1834;
    localparam int PHASE_LEN    = 120;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [31:0] FEATURE_KEEP =
        (NUM_FEATURES >= 32) ? 32'hFFFF_FFFF : ((32'd1 << NUM_FEATURES) - 32'd1);
    localparam logic [31:0] WEIGHT_KEEP =
        (WEIGHT_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WEIGHT_BITS) - 32'd1);

    // idle percentages per phase: none, sender, receiver, both
    localparam int SEND_IDLE_PCT [4] = '{0, 80, 0, 11};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 80, 11};

    typedef struct {
        tpwv_pkg::tpwv_op_t op;
        logic [5:0]         index;
        logic               valid;
        logic               cls;
        logic [31:0]        mask;
        logic [31:0]        vals;
        logic [15:0]        weight;
        logic [31:0]        obj;
        int                 phase;
        bit                 drain;
    } vote_item_t;

    typedef struct {
        tpwv_pkg::tpwv_decision_t     decision;
        logic [tpwv_pkg::SCORE_W-1:0] score_zero;
        logic [tpwv_pkg::SCORE_W-1:0] score_one;
    } vote_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    tpwv_in_if  item_ch ();
    tpwv_out_if result_ch ();

    ternary_pattern_weighted_vote #(
        .NUM_FEATURES (NUM_FEATURES),
        .NUM_PATTERNS (NUM_PATTERNS),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    // pattern table as the block should hold it
    logic        tbl_valid  [NUM_PATTERNS];
    logic        tbl_class  [NUM_PATTERNS];
    logic [31:0] tbl_mask   [NUM_PATTERNS];
    logic [31:0] tbl_values [NUM_PATTERNS];
    logic [31:0] tbl_weight [NUM_PATTERNS];

    // generator's view of the table, used to build matching objects
    logic [31:0] gen_mask [64];
    logic [31:0] gen_vals [64];

    vote_item_t   vote_pending[$];
    vote_result_t vote_expected[$];
    int           mismatches = 0;
    int           cur_phase  = 0;
    int           cycle_count = 0;
    int           gen_phase  = 0;
    bit           gen_drain  = 1'b0;

    // ------------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ternary_pattern_weighted_vote test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic vote_result_t tally_votes(logic [31:0] obj);
        vote_result_t res;
        int unsigned  s0;
        int unsigned  s1;
        logic [31:0]  care;
        int           i;
        s0 = 0;
        s1 = 0;
        for (i = 0; i < NUM_PATTERNS; i++)
        begin
            if (tbl_valid[i])
            begin
                care = tbl_mask[i] & FEATURE_KEEP;
                if (((tbl_values[i] ^ obj) & care) == 32'd0)
                begin
                    // scores saturate at the top of the score field
                    if (tbl_class[i])
                        s1 = (s1 + tbl_weight[i] > tpwv_pkg::SCORE_MAX) ?
                             tpwv_pkg::SCORE_MAX : s1 + tbl_weight[i];
                    else
                        s0 = (s0 + tbl_weight[i] > tpwv_pkg::SCORE_MAX) ?
                             tpwv_pkg::SCORE_MAX : s0 + tbl_weight[i];
                end
            end
        end
        if (s0 > s1)
            res.decision = tpwv_pkg::DEC_ZERO;
        else if (s0 < s1)
            res.decision = tpwv_pkg::DEC_ONE;
        else
            res.decision = tpwv_pkg::DEC_UNDECIDED;
        res.score_zero = s0[tpwv_pkg::SCORE_W-1:0];
        res.score_one  = s1[tpwv_pkg::SCORE_W-1:0];
        return res;
    endfunction

    // applies the transaction on the item channel and queues its result
    task automatic record_transaction();
        vote_result_t res;
        int           idx;
        idx = int'(item_ch.entry_index);
        if (item_ch.cmd == tpwv_pkg::OP_WRITE)
        begin
            // out-of-range slots are dropped, the acknowledge still comes
            if (idx < NUM_PATTERNS)
            begin
                tbl_valid[idx]  = item_ch.entry_valid;
                tbl_class[idx]  = item_ch.entry_class;
                tbl_mask[idx]   = item_ch.care_mask;
                tbl_values[idx] = item_ch.care_values;
                tbl_weight[idx] = {16'd0, item_ch.entry_weight} & WEIGHT_KEEP;
            end
            res.decision   = tpwv_pkg::DEC_UNDECIDED;
            res.score_zero = '0;
            res.score_one  = '0;
        end
        else
        begin
            res = tally_votes(item_ch.object_bits);
        end
        vote_expected = {vote_expected, res};
    endtask

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    task automatic add_write(int idx, logic ev, logic cls, logic [31:0] mask,
                             logic [31:0] vals, logic [15:0] weight);
        vote_item_t it;
        it.op     = tpwv_pkg::OP_WRITE;
        it.index  = idx[5:0];
        it.valid  = ev;
        it.cls    = cls;
        it.mask   = mask;
        it.vals   = vals;
        it.weight = weight;
        it.obj    = $urandom;
        it.phase  = gen_phase;
        it.drain  = gen_drain;
        gen_drain = 1'b0;
        gen_mask[idx[5:0]] = mask;
        gen_vals[idx[5:0]] = vals;
        vote_pending = {vote_pending, it};
    endtask

    task automatic add_classify(logic [31:0] obj);
        vote_item_t it;
        it.op     = tpwv_pkg::OP_CLASSIFY;
        it.index  = 6'($urandom);
        it.valid  = 1'($urandom);
        it.cls    = 1'($urandom);
        it.mask   = $urandom;
        it.vals   = $urandom;
        it.weight = 16'($urandom);
        it.obj    = obj;
        it.phase  = gen_phase;
        it.drain  = gen_drain;
        gen_drain = 1'b0;
        vote_pending = {vote_pending, it};
    endtask

    // masks of mixed density so that patterns match often enough
    function automatic logic [31:0] pick_mask();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
            4, 5:    return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        int sel;
        sel = $urandom_range(19);
        if (sel < 2)
            return 16'hFFFF;
        else if (sel == 2)
            return 16'd0;
        else
            return 16'($urandom);
    endfunction

    initial
    begin
        int          k;
        int          slot;
        logic [31:0] obj;

        for (k = 0; k < 64; k++)
        begin
            gen_mask[k] = '0;
            gen_vals[k] = '0;
        end
        for (k = 0; k < NUM_PATTERNS; k++)
        begin
            tbl_valid[k] = 1'b0;
        end

        // directed part
        add_classify(32'd0);                                        // empty table ties
        add_write(0, 1'b1, 1'b0, 32'd0, 32'h1234_5678, 16'hFFFF);   // empty mask
        add_classify(32'hFFFF_FFFF);
        add_write(63, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_classify(32'hFFFF_FFFF);                                // tie with weight
        add_classify(32'd0);
        add_write(1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0, 16'd1);
        add_classify(32'd0);
        add_write(0, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF); // clear entry
        add_classify(32'd0);
        add_write(5, 1'b1, 1'b0, 32'h8000_0001, 32'h8000_0000, 16'd0);    // zero weight
        add_classify(32'h8000_0000);
        add_classify(32'h8000_0001);
        add_write(63, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0);
        add_write(2, 1'b1, 1'b0, 32'h0000_FFFF, 32'h0000_A5A5, 16'h8000);
        add_write(3, 1'b1, 1'b1, 32'hFFFF_0000, 32'h5A5A_0000, 16'h7FFF);
        add_classify(32'h5A5A_A5A5);
        add_classify(32'hFFFF_FFFF);

        // random part, phases rotate in blocks with a drain at each start
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            gen_phase = (k / PHASE_LEN) % 4;
            if (k % PHASE_LEN == 0)
                gen_drain = 1'b1;
            if ($urandom_range(99) < 40)
            begin
                add_write($urandom_range(63), $urandom_range(9) != 0, 1'($urandom),
                          pick_mask(), $urandom, pick_weight());
            end
            else if ($urandom_range(3) != 0)
            begin
                // object that satisfies one table entry, other bits random
                slot = $urandom_range(63);
                obj  = (gen_vals[slot] & gen_mask[slot]) | ($urandom & ~gen_mask[slot]);
                add_classify(obj);
            end
            else
            begin
                add_classify($urandom);
            end
        end

        @(posedge clk);
        while (vote_pending.size() != 0 || item_ch.valid || vote_expected.size() != 0)
            @(posedge clk);
        repeat (NUM_PATTERNS + 16) @(posedge clk);
        if (mismatches == 0)
            $display("ternary_pattern_weighted_vote test passed");
        else
            $display("ternary_pattern_weighted_vote test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver: presents pending items, records each accepted transaction
    // ------------------------------------------------------------------------
    function automatic bit may_send();
        if (vote_pending.size() == 0)
            return 1'b0;
        // a drain item holds off until every result so far has come back
        if (vote_pending[0].drain && (vote_expected.size() != 0 || item_ch.valid))
            return 1'b0;
        return $urandom_range(99) >= SEND_IDLE_PCT[vote_pending[0].phase];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vote_item_t nxt;
        if (!rst_n)
        begin
            item_ch.valid        <= 1'b0;
            item_ch.cmd          <= tpwv_pkg::OP_WRITE;
            item_ch.entry_index  <= '0;
            item_ch.entry_valid  <= 1'b0;
            item_ch.entry_class  <= 1'b0;
            item_ch.care_mask    <= '0;
            item_ch.care_values  <= '0;
            item_ch.entry_weight <= '0;
            item_ch.object_bits  <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                record_transaction();
            if (!item_ch.valid || item_ch.ready)
            begin
                if (may_send())
                begin
                    nxt = vote_pending.pop_front();
                    cur_phase            = nxt.phase;
                    item_ch.valid        <= 1'b1;
                    item_ch.cmd          <= nxt.op;
                    item_ch.entry_index  <= nxt.index;
                    item_ch.entry_valid  <= nxt.valid;
                    item_ch.entry_class  <= nxt.cls;
                    item_ch.care_mask    <= nxt.mask;
                    item_ch.care_values  <= nxt.vals;
                    item_ch.entry_weight <= nxt.weight;
                    item_ch.object_bits  <= nxt.obj;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        vote_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (vote_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result transaction dec=%0d s0=%0d s1=%0d",
                                 $time, result_ch.decision, result_ch.score_zero,
                                 result_ch.score_one);
                end
                else
                begin
                    want = vote_expected.pop_front();
                    if (result_ch.decision !== want.decision
                        || result_ch.score_zero !== want.score_zero
                        || result_ch.score_one !== want.score_one)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp dec=%0d s0=%0d s1=%0d got dec=%0d s0=%0d s1=%0d",
                                     $time, want.decision, want.score_zero, want.score_one,
                                     result_ch.decision, result_ch.score_zero,
                                     result_ch.score_one);
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= RECV_STALL_PCT[cur_phase]);
        end
    end

endmodule

@@ filelist.f @@
rtl/tpwv_pkg.sv
rtl/tpwv_if.sv
rtl/tpwv_front.sv
rtl/tpwv_queue.sv
rtl/tpwv_back.sv
rtl/ternary_pattern_weighted_vote.sv
rtl/tpwv_checker.sv
tb/ternary_pattern_weighted_vote_tb.sv
